>>> rtl/framed_keyword_command_parser_top_defines.svh
// Assertion macros shared by the command parser RTL.
`ifndef FRAMED_KEYWORD_COMMAND_PARSER_TOP_DEFINES_SVH
`define FRAMED_KEYWORD_COMMAND_PARSER_TOP_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define FKCP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fkcp assertion failed");

// Condition must hold in the cycle after the trigger.
`define FKCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fkcp assertion failed");

`endif

>>> rtl/fkcp_pkg.sv
// Types, codes and keyword tables for the framed keyword command parser.
`timescale 1ns / 1ps

package fkcp_pkg;

   // Default frame buffer size in bytes
   localparam int BUFFER_BYTES_DEFAULT = 256;

   // Depth of the queue between the front and back parts
   localparam int QUEUE_DEPTH = 2;

   localparam int KW_COUNT = 8;
   localparam int KW_SLOTS = 24;
   localparam logic [8:0] MATCH_MAX = 9'd511;

   localparam logic [7:0] CHAR_OPEN  = 8'h21;  // '!'
   localparam logic [7:0] CHAR_CLOSE = 8'h3B;  // ';'

   // Keyword indexes
   localparam logic [2:0] KW_RESET      = 3'd0;
   localparam logic [2:0] KW_REGISTER   = 3'd1;
   localparam logic [2:0] KW_CREATE     = 3'd2;
   localparam logic [2:0] KW_RETRIEVE   = 3'd3;
   localparam logic [2:0] KW_UPDATE     = 3'd4;
   localparam logic [2:0] KW_DEREGISTER = 3'd5;
   localparam logic [2:0] KW_TEST_BEGIN = 3'd6;
   localparam logic [2:0] KW_TEST_END   = 3'd7;

   typedef enum logic [3:0] {
      ACT_NONE        = 4'd0,
      ACT_DEREG_RESET = 4'd1,
      ACT_REGISTER    = 4'd2,
      ACT_CREATE      = 4'd3,
      ACT_RETRIEVE    = 4'd4,
      ACT_UPDATE      = 4'd5,
      ACT_DEREGISTER  = 4'd6,
      ACT_ENTER_TEST  = 4'd7,
      ACT_EXIT_TEST   = 4'd8
   } action_type;

   typedef enum logic [2:0] {
      STS_IDLE         = 3'd0,
      STS_ACCEPTED     = 3'd1,
      STS_UNKNOWN      = 3'd2,
      STS_NOT_IN_TEST  = 3'd3,
      STS_ALREADY_TEST = 3'd4,
      STS_OVERRUN      = 3'd5
   } status_type;

   // Class of one beat, decided by the front part
   typedef enum logic [2:0] {
      KIND_READY = 3'd0,   // system ready event
      KIND_OPEN  = 3'd1,   // '!' byte
      KIND_CLOSE = 3'd2,   // ';' byte
      KIND_ZERO  = 3'd3,   // zero byte
      KIND_DATA  = 3'd4    // any other byte
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
   } item_type;

   typedef enum logic [0:0] {
      FRAME_IDLE = 1'b0,
      FRAME_OPEN = 1'b1
   } frame_state_type;

   // Keyword length
   function automatic logic [8:0] kw_len(input logic [2:0] k);
      logic [8:0] len;
      case (k)
         KW_RESET:      len = 9'd5;
         KW_REGISTER:   len = 9'd8;
         KW_CREATE:     len = 9'd15;
         KW_RETRIEVE:   len = 9'd21;
         KW_UPDATE:     len = 9'd15;
         KW_DEREGISTER: len = 9'd10;
         KW_TEST_BEGIN: len = 9'd9;
         KW_TEST_END:   len = 9'd7;
         default:       len = 9'd0;
      endcase
      return len;
   endfunction

   // Keyword text, right-aligned: the last character sits in the low byte
   function automatic logic [KW_SLOTS*8-1:0] kw_text(input logic [2:0] k);
      logic [KW_SLOTS*8-1:0] txt;
      case (k)
         KW_RESET:      txt = "reset";
         KW_REGISTER:   txt = "register";
         KW_CREATE:     txt = "createDataModel";
         KW_RETRIEVE:   txt = "retrieveNotifications";
         KW_UPDATE:     txt = "updateDataModel";
         KW_DEREGISTER: txt = "deregister";
         KW_TEST_BEGIN: txt = "testBegin";
         KW_TEST_END:   txt = "testEnd";
         default:       txt = '0;
      endcase
      return txt;
   endfunction

   // Character idx of keyword k, zero past its end
   function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [4:0] idx);
      logic [8:0]            len9;
      logic [4:0]            len5;
      logic [4:0]            pos;
      logic [KW_SLOTS*8-1:0] txt;
      logic [7:0]            ch;
      len9 = kw_len(k);
      len5 = len9[4:0];
      txt  = kw_text(k);
      pos  = len5 - idx - 5'd1;
      if (idx < len5) begin
         ch = txt[pos*8 +: 8];
      end else begin
         ch = 8'd0;
      end
      return ch;
   endfunction

endpackage

>>> rtl/fkcp_front.sv
// Front part: accepts input beats and classifies each one.
`timescale 1ns / 1ps

module fkcp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // byte_value
   input  logic               req_tuser,   // command
   output logic               item_valid,
   input  logic               item_ready,
   output fkcp_pkg::item_type item_data
);

   logic               valid_ff, valid_in;
   fkcp_pkg::item_type item_ff, item_in;
   logic               take;

   // Stage is free when empty or when its beat moves on this cycle
   assign req_tready = !valid_ff || item_ready;
   assign take       = req_tvalid && req_tready;

   // Classify the incoming beat
   always_comb begin
      item_in.value = req_tdata;
      if (req_tuser) begin
         item_in.kind = fkcp_pkg::KIND_READY;
      end else if (req_tdata == fkcp_pkg::CHAR_OPEN) begin
         item_in.kind = fkcp_pkg::KIND_OPEN;
      end else if (req_tdata == fkcp_pkg::CHAR_CLOSE) begin
         item_in.kind = fkcp_pkg::KIND_CLOSE;
      end else if (req_tdata == 8'd0) begin
         item_in.kind = fkcp_pkg::KIND_ZERO;
      end else begin
         item_in.kind = fkcp_pkg::KIND_DATA;
      end
   end

   assign valid_in = take || (valid_ff && !item_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = item_ff;

endmodule

>>> rtl/fkcp_queue.sv
// Short queue of classified beats between the front and back parts.
`timescale 1ns / 1ps

`include "framed_keyword_command_parser_top_defines.svh"

module fkcp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  fkcp_pkg::item_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output fkcp_pkg::item_type pop_data
);

   localparam int PTR_W = (fkcp_pkg::QUEUE_DEPTH > 1) ? $clog2(fkcp_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(fkcp_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT  = CNT_W'(fkcp_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_SLOT   = PTR_W'(fkcp_pkg::QUEUE_DEPTH - 1);

   fkcp_pkg::item_type slot_ff [fkcp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers must coincide whenever the queue is empty or full
   `FKCP_ASSERT_NOW(a_queue_ptr_count, clock, reset, (count_ff == '0) || (count_ff == FULL_COUNT), wr_ptr_ff == rd_ptr_ff)

endmodule

>>> rtl/fkcp_back.sv
// Back part: frame tracking, keyword matching, test mode and the result register.
`timescale 1ns / 1ps

`include "framed_keyword_command_parser_top_defines.svh"

module fkcp_back #(
   parameter int BUFFER_BYTES = fkcp_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   output logic               item_ready,
   input  fkcp_pkg::item_type item_data,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata    // action[3:0], status[6:4], test_mode[7]
);

   localparam int LEN_W = $clog2(BUFFER_BYTES + 1);
   localparam logic [LEN_W-1:0] LEN_LAST  = LEN_W'(BUFFER_BYTES - 1);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(BUFFER_BYTES);

   fkcp_pkg::frame_state_type state_ff, state_in;
   logic [LEN_W-1:0]          frame_len_ff, frame_len_in;
   logic [7:0]                alive_ff, alive_in;
   logic                      zero_seen_ff, zero_seen_in;
   logic [8:0]                match_len_ff, match_len_in;
   logic                      test_mode_ff, test_mode_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_data_ff, rsp_data_in;

   fkcp_pkg::action_type action;
   fkcp_pkg::status_type status;
   logic                 exec;
   logic                 overrun;
   logic                 hit_found;
   logic [2:0]           hit_idx;

   // Take a beat when the result register is free or being drained
   assign item_ready = !rsp_valid_ff || rsp_tready;
   assign exec       = item_valid && item_ready;
   assign overrun    = (frame_len_ff == LEN_LAST);

   // First live keyword whose length equals the text length
   always_comb begin
      hit_found = 1'b0;
      hit_idx   = '0;
      for (int k = 0; k < fkcp_pkg::KW_COUNT; k++) begin
         if (!hit_found && alive_ff[k] && (match_len_ff == fkcp_pkg::kw_len(3'(k)))) begin
            hit_found = 1'b1;
            hit_idx   = 3'(k);
         end
      end
   end

   // Frame state: next state
   always_comb begin
      state_in = state_ff;
      if (exec && item_data.kind != fkcp_pkg::KIND_READY) begin
         case (state_ff)
            fkcp_pkg::FRAME_IDLE: begin
               if (item_data.kind == fkcp_pkg::KIND_OPEN) begin
                  state_in = fkcp_pkg::FRAME_OPEN;
               end
            end
            fkcp_pkg::FRAME_OPEN: begin
               if (item_data.kind == fkcp_pkg::KIND_CLOSE || overrun) begin
                  state_in = fkcp_pkg::FRAME_IDLE;
               end
            end
            default: state_in = fkcp_pkg::FRAME_IDLE;
         endcase
      end
   end

   // Frame state: datapath and result
   always_comb begin
      frame_len_in = frame_len_ff;
      alive_in     = alive_ff;
      zero_seen_in = zero_seen_ff;
      match_len_in = match_len_ff;
      test_mode_in = test_mode_ff;
      action       = fkcp_pkg::ACT_NONE;
      status       = fkcp_pkg::STS_IDLE;
      if (item_data.kind == fkcp_pkg::KIND_READY) begin
         test_mode_in = 1'b0;
      end else begin
         case (state_ff)
            fkcp_pkg::FRAME_IDLE: begin
               if (item_data.kind == fkcp_pkg::KIND_OPEN) begin
                  frame_len_in = '0;
                  alive_in     = 8'hFF;
                  zero_seen_in = 1'b0;
                  match_len_in = '0;
               end
            end
            fkcp_pkg::FRAME_OPEN: begin
               if (item_data.kind == fkcp_pkg::KIND_CLOSE) begin
                  // Resolve the command and apply the test mode rules
                  if (!hit_found) begin
                     status = fkcp_pkg::STS_UNKNOWN;
                  end else if (hit_idx == fkcp_pkg::KW_TEST_BEGIN) begin
                     if (test_mode_ff) begin
                        status = fkcp_pkg::STS_ALREADY_TEST;
                     end else begin
                        test_mode_in = 1'b1;
                        action       = fkcp_pkg::ACT_ENTER_TEST;
                        status       = fkcp_pkg::STS_ACCEPTED;
                     end
                  end else if (!test_mode_ff) begin
                     status = fkcp_pkg::STS_NOT_IN_TEST;
                  end else begin
                     if (hit_idx == fkcp_pkg::KW_TEST_END) begin
                        test_mode_in = 1'b0;
                     end
                     action = fkcp_pkg::action_type'({1'b0, hit_idx} + 4'd1);
                     status = fkcp_pkg::STS_ACCEPTED;
                  end
               end else begin
                  // Text stops growing at the first zero byte
                  if (!zero_seen_ff) begin
                     if (item_data.kind == fkcp_pkg::KIND_ZERO) begin
                        zero_seen_in = 1'b1;
                     end else begin
                        for (int k = 0; k < fkcp_pkg::KW_COUNT; k++) begin
                           if (match_len_ff >= fkcp_pkg::kw_len(3'(k)) ||
                               fkcp_pkg::kw_char(3'(k), match_len_ff[4:0]) != item_data.value)
                           begin
                              alive_in[k] = 1'b0;
                           end
                        end
                        if (match_len_ff != fkcp_pkg::MATCH_MAX) begin
                           match_len_in = match_len_ff + 9'd1;
                        end
                     end
                  end
                  frame_len_in = frame_len_ff + LEN_W'(1);
                  if (overrun) begin
                     status = fkcp_pkg::STS_OVERRUN;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid_in = exec || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = {test_mode_in, status, action};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fkcp_pkg::FRAME_IDLE;
         frame_len_ff <= '0;
         alive_ff     <= '0;
         zero_seen_ff <= 1'b0;
         match_len_ff <= '0;
         test_mode_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (exec) begin
            state_ff     <= state_in;
            frame_len_ff <= frame_len_in;
            alive_ff     <= alive_in;
            zero_seen_ff <= zero_seen_in;
            match_len_ff <= match_len_in;
            test_mode_ff <= test_mode_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // An open frame never holds a full buffer
   `FKCP_ASSERT_NOW(a_open_below_limit, clock, reset, state_ff == fkcp_pkg::FRAME_OPEN, frame_len_ff < LEN_LIMIT)
   // Entering test mode leaves the flag set
   `FKCP_ASSERT_NEXT(a_enter_sets_mode, clock, reset, exec && action == fkcp_pkg::ACT_ENTER_TEST, test_mode_ff)
   // An accepted command always carries an action
   `FKCP_ASSERT_NOW(a_accept_has_action, clock, reset, rsp_valid_ff && rsp_data_ff[6:4] == fkcp_pkg::STS_ACCEPTED, rsp_data_ff[3:0] != fkcp_pkg::ACT_NONE)

endmodule

>>> rtl/framed_keyword_command_parser_top.sv
// Top level of the framed keyword command parser.
`timescale 1ns / 1ps

// Parses a byte stream of '!'-opened, ';'-closed command frames and returns one
// result beat (action, status, test mode) for every input beat. A new beat is
// taken every cycle while the result side does not stall; a result passes the
// front classify register, a queue slot and the result register, and the
// sustained rate is one beat per cycle, set by the keyword match in the
// back part. Frames reaching BUFFER_BYTES bytes are dropped with an overrun.
module framed_keyword_command_parser_top #(
   parameter int BUFFER_BYTES = fkcp_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // byte_value[7:0]
   input  logic       req_tuser,    // command
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata     // action[3:0], status[6:4], test_mode[7]
);

   logic               front_valid, front_ready;
   fkcp_pkg::item_type front_item;
   logic               queue_valid, queue_ready;
   fkcp_pkg::item_type queue_item;

   fkcp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item_data  (front_item)
   );

   fkcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_item)
   );

   fkcp_back #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item_ready (queue_ready),
      .item_data  (queue_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> tb/sv/framed_keyword_command_parser_top_tb.sv
// Self-checking testbench for the framed keyword command parser top level.
`timescale 1ns / 1ps

module framed_keyword_command_parser_top_tb;

   localparam int BUF_BYTES   = fkcp_pkg::BUFFER_BYTES_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 12;

   typedef struct packed {
      fkcp_pkg::action_type act;
      fkcp_pkg::status_type sts;
      logic                 mode;
   } parse_rsp_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // byte_value[7:0]
   logic       req_tuser  = 1'b0;    // command
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // action[3:0], status[6:4], test_mode[7]

   // Keyword spelling, indexed by the package keyword codes
   string kw_word [8] = '{"reset", "register", "createDataModel", "retrieveNotifications",
                          "updateDataModel", "deregister", "testBegin", "testEnd"};

   // Parser state mirrored by the predictor
   logic       open_flag;
   logic [8:0] byte_count;
   logic [7:0] live_mask;
   logic       text_ended;
   logic [8:0] text_len;
   logic       test_on;

   parse_rsp_type pending_rsp [$];
   int            fail_count  = 0;
   int            beat_count  = 0;
   int            burst_left  = 0;
   int            cycle_count = 0;
   int            ready_mode  = 0;
   int            ready_left  = 0;

   framed_keyword_command_parser_top #(
      .BUFFER_BYTES(BUF_BYTES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Run guard
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("framed_keyword_command_parser_top regression: fail");
         $finish;
      end
   end

   // Receiver backpressure: pick a mode, hold it for a while
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_left = $urandom_range(4, 40);
      end
      ready_left = ready_left - 1;
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (ready_left % 8 == 0);
      endcase
   end

   function automatic void clear_model();
      open_flag  = 1'b0;
      byte_count = '0;
      live_mask  = '0;
      text_ended = 1'b0;
      text_len   = '0;
      test_on    = 1'b0;
   endfunction

   // Advance the mirrored parser by one input beat and return its result beat
   function automatic parse_rsp_type parse_step(input logic cmd, input logic [7:0] value);
      parse_rsp_type r;
      int            hit;
      r.act = fkcp_pkg::ACT_NONE;
      r.sts = fkcp_pkg::STS_IDLE;
      hit   = -1;
      if (cmd) begin
         test_on = 1'b0;
      end else if (open_flag) begin
         if (value == fkcp_pkg::CHAR_CLOSE) begin
            // frame closes: first live keyword of exactly the text length wins
            for (int k = 0; k < 8; k++) begin
               if (hit < 0 && live_mask[k] && text_len == kw_word[k].len()) hit = k;
            end
            if (hit < 0) begin
               r.sts = fkcp_pkg::STS_UNKNOWN;
            end else if (hit == fkcp_pkg::KW_TEST_BEGIN) begin
               if (test_on) begin
                  r.sts = fkcp_pkg::STS_ALREADY_TEST;
               end else begin
                  test_on = 1'b1;
                  r.act   = fkcp_pkg::ACT_ENTER_TEST;
                  r.sts   = fkcp_pkg::STS_ACCEPTED;
               end
            end else if (!test_on) begin
               r.sts = fkcp_pkg::STS_NOT_IN_TEST;
            end else begin
               if (hit == fkcp_pkg::KW_TEST_END) test_on = 1'b0;
               r.act = fkcp_pkg::action_type'(hit + 1);
               r.sts = fkcp_pkg::STS_ACCEPTED;
            end
            open_flag = 1'b0;
         end else begin
            // text freezes at the first zero byte
            if (!text_ended) begin
               if (value == 8'h00) begin
                  text_ended = 1'b1;
               end else begin
                  for (int k = 0; k < 8; k++) begin
                     if (live_mask[k] && (text_len >= kw_word[k].len() ||
                                          kw_word[k][text_len] != value))
                        live_mask[k] = 1'b0;
                  end
                  if (text_len < fkcp_pkg::MATCH_MAX) text_len = text_len + 9'd1;
               end
            end
            if (byte_count < BUF_BYTES) byte_count = byte_count + 9'd1;
            if (byte_count >= BUF_BYTES) begin
               open_flag = 1'b0;
               r.sts     = fkcp_pkg::STS_OVERRUN;
            end
         end
      end else if (value == fkcp_pkg::CHAR_OPEN) begin
         open_flag  = 1'b1;
         byte_count = '0;
         live_mask  = 8'hFF;
         text_ended = 1'b0;
         text_len   = '0;
      end
      r.mode = test_on;
      return r;
   endfunction

   // Result checker
   always @(posedge clock) begin : rsp_check
      parse_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected rsp beat: action %0d status %0d mode %0d", $time,
                     rsp_tdata[3:0], rsp_tdata[6:4], rsp_tdata[7]);
            fail_count = fail_count + 1;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tdata[3:0] !== want.act || rsp_tdata[6:4] !== want.sts ||
                rsp_tdata[7] !== want.mode) begin
               $display({"%0t: rsp mismatch: expected action %0d status %0d mode %0d,",
                         " got action %0d status %0d mode %0d"},
                        $time, want.act, want.sts, want.mode,
                        rsp_tdata[3:0], rsp_tdata[6:4], rsp_tdata[7]);
               fail_count = fail_count + 1;
            end
         end
      end
   end

   // Send one beat; called and returning just after a falling edge
   task automatic send_beat(input logic cmd, input logic [7:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_rsp.push_back(parse_step(cmd, value));
      beat_count = beat_count + 1;
      burst_left = burst_left - 1;
      @(negedge clock);
   endtask

   task automatic send_frame(input string text);
      send_beat(1'b0, fkcp_pkg::CHAR_OPEN);
      for (int i = 0; i < text.len(); i++) send_beat(1'b0, text[i]);
      send_beat(1'b0, fkcp_pkg::CHAR_CLOSE);
   endtask

   // Hold the sender until every pending result has been returned
   task automatic drain_rsp();
      req_tvalid = 1'b0;
      burst_left = 0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // Frame of n bytes, none of them the closing byte
   task automatic long_frame(input int n);
      logic [7:0] b;
      send_beat(1'b0, fkcp_pkg::CHAR_OPEN);
      repeat (n) begin
         b = 8'($urandom_range(0, 255));
         if (b == fkcp_pkg::CHAR_CLOSE) b = "x";
         send_beat(1'b0, b);
      end
      send_beat(1'b0, fkcp_pkg::CHAR_CLOSE);
   endtask

   task automatic test_outside_bytes();
      send_beat(1'b0, 8'h00);
      send_beat(1'b0, 8'hFF);
      send_beat(1'b0, fkcp_pkg::CHAR_CLOSE);
      send_beat(1'b0, "a");
   endtask

   task automatic test_refused_outside_test();
      send_frame("register");
   endtask

   task automatic test_enter_test();
      send_frame("testBegin");
      send_frame("testBegin");
   endtask

   task automatic test_unknown_commands();
      send_frame("res");
      send_frame("resets");
      send_frame("!reset");
      send_frame("");
   endtask

   task automatic test_zero_byte();
      send_beat(1'b0, fkcp_pkg::CHAR_OPEN);
      send_frame("reset");
      send_beat(1'b0, fkcp_pkg::CHAR_OPEN);
      send_frame("reset");
      // text ends at the zero byte, trailing bytes ignored
      send_beat(1'b0, fkcp_pkg::CHAR_OPEN);
      for (int i = 0; i < kw_word[fkcp_pkg::KW_RESET].len(); i++)
         send_beat(1'b0, kw_word[fkcp_pkg::KW_RESET][i]);
      send_beat(1'b0, 8'h00);
      send_beat(1'b0, "z");
      send_beat(1'b0, 8'hFF);
      send_beat(1'b0, fkcp_pkg::CHAR_CLOSE);
      send_beat(1'b0, fkcp_pkg::CHAR_OPEN);
      send_beat(1'b0, 8'h00);
      send_beat(1'b0, fkcp_pkg::CHAR_CLOSE);
   endtask

   task automatic test_each_keyword();
      for (int k = 0; k < 8; k++) begin
         if (k != fkcp_pkg::KW_TEST_BEGIN) send_frame(kw_word[k]);
      end
   endtask

   task automatic test_ready_event();
      send_frame("testBegin");
      send_beat(1'b0, fkcp_pkg::CHAR_OPEN);
      send_beat(1'b0, "u");
      send_beat(1'b0, "p");
      send_beat(1'b1, fkcp_pkg::CHAR_OPEN);   // clears test mode, frame stays open
      send_beat(1'b1, 8'hFF);
      for (int i = 2; i < kw_word[fkcp_pkg::KW_UPDATE].len(); i++)
         send_beat(1'b0, kw_word[fkcp_pkg::KW_UPDATE][i]);
      send_beat(1'b0, fkcp_pkg::CHAR_CLOSE);
   endtask

   task automatic test_overrun();
      // one byte short of the buffer closes normally
      long_frame(BUF_BYTES - 1);
      // reaching the buffer size drops the frame; the closing byte is then ignored
      long_frame(BUF_BYTES);
      send_frame("testBegin");
      long_frame(BUF_BYTES + 2);
   endtask

   // Keyword-based frame with random damage
   task automatic rand_frame();
      logic [7:0] body [$];
      int         pick;
      int         n;
      pick = ($urandom_range(0, 3) == 0) ? fkcp_pkg::KW_TEST_BEGIN : $urandom_range(0, 7);
      for (int i = 0; i < kw_word[pick].len(); i++) body.push_back(kw_word[pick][i]);
      case ($urandom_range(0, 9))
         5: begin
            n = $urandom_range(0, body.size() - 1);
            while (body.size() > n) void'(body.pop_back());
         end
         6: body.push_back(8'($urandom_range(8'h20, 8'h7E)));
         7: body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(1, 255));
         8: begin
            body.push_back(8'h00);
            repeat ($urandom_range(0, 5)) body.push_back(8'($urandom_range(0, 255)));
         end
         9: begin
            body.delete();
            repeat ($urandom_range(0, 12)) body.push_back(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
      send_beat(1'b0, fkcp_pkg::CHAR_OPEN);
      foreach (body[i]) begin
         if ($urandom_range(0, 39) == 0) send_beat(1'b1, 8'($urandom_range(0, 255)));
         send_beat(1'b0, body[i]);
      end
      // now and then leave the frame open
      if ($urandom_range(0, 14) != 0) send_beat(1'b0, fkcp_pkg::CHAR_CLOSE);
   endtask

   task automatic test_random_traffic(input int count);
      int start;
      int r;
      start = beat_count;
      while (beat_count - start < count) begin
         r = $urandom_range(0, 199);
         if (r < 160) rand_frame();
         else if (r < 176) send_beat(1'b1, 8'($urandom_range(0, 255)));
         else if (r < 196) send_beat(1'b0, 8'($urandom_range(0, 255)));
         else if (r < 198) long_frame($urandom_range(BUF_BYTES - 6, BUF_BYTES + 2));
         else drain_rsp();
      end
   endtask

   initial begin
      clear_model();
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_outside_bytes();
      test_refused_outside_test();
      test_enter_test();
      test_unknown_commands();
      test_zero_byte();
      test_each_keyword();
      test_ready_event();
      drain_rsp();
      test_overrun();
      drain_rsp();
      test_random_traffic(150);

      // flush and let any stray beat show up
      drain_rsp();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("framed_keyword_command_parser_top regression: pass");
      end else begin
         $display("framed_keyword_command_parser_top regression: fail");
      end
      $finish;
   end

endmodule
